// ===== hw/rtl/vbfs_pkg.sv =====
`default_nettype none

package vbfs_pkg;

    localparam int COORD_W = 8;
    localparam int BYTE_W  = 8;

    localparam logic [2:0] OP_WRITE       = 3'd0;
    localparam logic [2:0] OP_READ        = 3'd1;
    localparam logic [2:0] OP_CLEAR_ALL   = 3'd2;
    localparam logic [2:0] OP_CLEAR_LAYER = 3'd3;
    localparam logic [2:0] OP_FILL_LAYER  = 3'd4;

    typedef enum logic [1:0] {
        CMD_NOP   = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SWEEP = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                ok;
        logic                lit;
        logic [COORD_W-1:0]  col;
        logic [BYTE_W-1:0]   fill;
    } cmd_ctl_t;

    typedef struct packed {
        logic in_range;
        logic voxel_bit;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vbfs_queue.sv =====
`default_nettype none

module vbfs_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vbfs_front.sv =====
`default_nettype none

module vbfs_front
    import vbfs_pkg::*;
#(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128,
    parameter int LAYER_COUNT = 8,
    localparam int TOTAL_ROWS = GRID_HEIGHT * LAYER_COUNT,
    localparam int ROW_AW     = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         op,
    input  wire logic [COORD_W-1:0] x_coord,
    input  wire logic [COORD_W-1:0] y_coord,
    input  wire logic [COORD_W-1:0] z_layer,
    input  wire logic               lit,
    input  wire logic [BYTE_W-1:0]  fill_byte,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data,
    input  wire logic               cmd_full,
    input  wire logic               init_busy,
    output logic                    cmd_push,
    output cmd_ctl_t                cmd_ctl,
    output logic [ROW_AW-1:0]       cmd_row,
    output logic [ROW_AW-1:0]       cmd_last
);

    localparam logic [COORD_W:0] W_LIM = (COORD_W + 1)'(GRID_WIDTH);
    localparam logic [COORD_W:0] H_LIM = (COORD_W + 1)'(GRID_HEIGHT);
    localparam logic [COORD_W:0] L_LIM = (COORD_W + 1)'(LAYER_COUNT);

    logic               swap_reg;
    logic               swap_next;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               z_ok;
    logic               voxel_ok;
    logic [ROW_AW-1:0]  layer_base;
    logic [ROW_AW-1:0]  row_addr;

    assign cfg_ready = 1'b1;
    assign swap_next = (cfg_valid && cfg_ready) ? cfg_data : swap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg <= 1'b0;
        end
        else
        begin
            swap_reg <= swap_next;
        end
    end

    assign full     = cmd_full || init_busy;
    assign cmd_push = push && !full;

    always_comb
    begin
        col        = swap_reg ? y_coord : x_coord;
        row        = swap_reg ? x_coord : y_coord;
        z_ok       = ({1'b0, z_layer} < L_LIM);
        voxel_ok   = ({1'b0, x_coord} < W_LIM) && ({1'b0, y_coord} < H_LIM) && z_ok
                     && ({1'b0, col} < W_LIM) && ({1'b0, row} < H_LIM);
        layer_base = ROW_AW'(ROW_AW'(z_layer) * ROW_AW'(GRID_HEIGHT));
        row_addr   = layer_base + ROW_AW'(row);

        cmd_ctl.kind = CMD_NOP;
        cmd_ctl.ok   = 1'b0;
        cmd_ctl.lit  = lit;
        cmd_ctl.col  = col;
        cmd_ctl.fill = '0;
        cmd_row      = row_addr;
        cmd_last     = row_addr;

        case (op)
            OP_WRITE:
            begin
                cmd_ctl.kind = voxel_ok ? CMD_WRITE : CMD_NOP;
                cmd_ctl.ok   = voxel_ok;
            end
            OP_READ:
            begin
                cmd_ctl.kind = voxel_ok ? CMD_READ : CMD_NOP;
                cmd_ctl.ok   = voxel_ok;
            end
            OP_CLEAR_ALL:
            begin
                cmd_ctl.kind = CMD_SWEEP;
                cmd_ctl.ok   = 1'b1;
                cmd_row      = '0;
                cmd_last     = ROW_AW'(TOTAL_ROWS - 1);
            end
            OP_CLEAR_LAYER, OP_FILL_LAYER:
            begin
                cmd_ctl.kind = z_ok ? CMD_SWEEP : CMD_NOP;
                cmd_ctl.ok   = z_ok;
                cmd_ctl.fill = (op == OP_FILL_LAYER) ? fill_byte : '0;
                cmd_row      = layer_base;
                cmd_last     = layer_base + ROW_AW'(GRID_HEIGHT - 1);
            end
            default:
            begin
                cmd_ctl.kind = CMD_NOP;
                cmd_ctl.ok   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vbfs_back.sv =====
`default_nettype none

module vbfs_back
    import vbfs_pkg::*;
#(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128,
    parameter int LAYER_COUNT = 8,
    localparam int TOTAL_ROWS = GRID_HEIGHT * LAYER_COUNT,
    localparam int ROW_AW     = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_empty,
    input  wire cmd_ctl_t          cmd_ctl,
    input  wire logic [ROW_AW-1:0] cmd_row,
    input  wire logic [ROW_AW-1:0] cmd_last,
    output logic                   cmd_pop,
    input  wire logic              res_full,
    output logic                   res_push,
    output result_t                res,
    output logic                   init_busy
);

    localparam int ROW_BYTES = (GRID_WIDTH + 7) / 8;
    localparam int ROW_BITS  = ROW_BYTES * BYTE_W;
    localparam int COL_W     = $clog2(ROW_BITS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RMW   = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    cmd_ctl_t            cmd_reg;
    cmd_ctl_t            cmd_next;
    logic [ROW_AW-1:0]   addr_reg;
    logic [ROW_AW-1:0]   addr_next;
    logic [ROW_AW-1:0]   last_reg;
    logic [ROW_AW-1:0]   last_next;
    logic [BYTE_W-1:0]   fill_reg;
    logic [BYTE_W-1:0]   fill_next;
    logic                report_reg;
    logic                report_next;

    logic [ROW_BITS-1:0] mem [TOTAL_ROWS];
    logic [ROW_BITS-1:0] rdata_reg;
    logic                mem_we;
    logic [ROW_AW-1:0]   mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [COL_W-1:0]    col_idx;
    logic [ROW_BITS-1:0] row_mod;

    assign init_busy = (state_reg == ST_SWEEP) && !report_reg;
    assign col_idx   = cmd_reg.col[COL_W-1:0];

    always_comb
    begin
        row_mod          = rdata_reg;
        row_mod[col_idx] = cmd_reg.lit;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        last_next   = last_reg;
        fill_next   = fill_reg;
        report_next = report_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res         = '0;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = {ROW_BYTES{fill_reg}};
        mem_re      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_ctl;
                    case (cmd_ctl.kind)
                        CMD_WRITE, CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            addr_next  = cmd_row;
                            state_next = ST_RMW;
                        end
                        CMD_SWEEP:
                        begin
                            addr_next   = cmd_row;
                            last_next   = cmd_last;
                            fill_next   = cmd_ctl.fill;
                            report_next = 1'b1;
                            state_next  = ST_SWEEP;
                        end
                        default:
                        begin
                            res_push     = 1'b1;
                            res.in_range = cmd_ctl.ok;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                res_push     = 1'b1;
                res.in_range = 1'b1;
                if (cmd_reg.kind == CMD_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = row_mod;
                end
                else
                begin
                    res.voxel_bit = rdata_reg[col_idx];
                end
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                if (addr_reg == last_reg)
                begin
                    res_push     = report_reg;
                    res.in_range = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ROW_AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            cmd_reg    <= '0;
            addr_reg   <= '0;
            last_reg   <= ROW_AW'(TOTAL_ROWS - 1);
            fill_reg   <= '0;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            addr_reg   <= addr_next;
            last_reg   <= last_next;
            fill_reg   <= fill_next;
            report_reg <= report_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[addr_next];
        end
    end

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < TOTAL_ROWS))
        else $error("Row write falls outside the store.");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("Result pushed into a full result queue.");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> ((state_reg == ST_IDLE) && !cmd_empty && !res_full))
        else $error("Command taken while the back end is busy.");

    a_rmw_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW) |=> (state_reg == ST_IDLE))
        else $error("Voxel access did not finish in its second cycle.");

endmodule

`default_nettype wire

// ===== hw/rtl/voxel_bit_frame_store.sv =====
// Bit-packed voxel store of LAYER_COUNT layers of GRID_HEIGHT rows, held as one memory row
// per grid row, so that a row is ceil(GRID_WIDTH/8) bytes wide. A front stage checks and
// addresses each item and places it in a two-entry command queue; a back stage executes it
// through the row memory and places the result in a two-entry result queue. A voxel write
// or read first reads the row, then writes the changed row back or selects the bit. A layer
// clear or fill and a clear of all layers write one memory row per cycle. Items that do
// nothing are answered as they are taken. After reset the store is cleared by a pass over
// all LAYER_COUNT * GRID_HEIGHT rows (1024 with the default sizes), during which full stays
// high; configuration writes are taken throughout.
`default_nettype none

module voxel_bit_frame_store
    import vbfs_pkg::*;
#(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128,
    parameter int LAYER_COUNT = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         op,
    input  wire logic [COORD_W-1:0] x_coord,
    input  wire logic [COORD_W-1:0] y_coord,
    input  wire logic [COORD_W-1:0] z_layer,
    input  wire logic               lit,
    input  wire logic [BYTE_W-1:0]  fill_byte,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    in_range,
    output logic                    voxel_bit
);

    localparam int TOTAL_ROWS = GRID_HEIGHT * LAYER_COUNT;
    localparam int ROW_AW     = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
    localparam int CMD_W      = $bits(cmd_ctl_t) + 2 * ROW_AW;
    localparam int RES_W      = $bits(result_t);

    logic              init_busy;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_push;
    logic              cmd_pop;
    cmd_ctl_t          fe_ctl;
    logic [ROW_AW-1:0] fe_row;
    logic [ROW_AW-1:0] fe_last;
    logic [CMD_W-1:0]  q_out;
    cmd_ctl_t          be_ctl;
    logic [ROW_AW-1:0] be_row;
    logic [ROW_AW-1:0] be_last;
    logic              res_full;
    logic              res_push;
    result_t           res_in;
    result_t           res_out;

    vbfs_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .LAYER_COUNT (LAYER_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .z_layer   (z_layer),
        .lit       (lit),
        .fill_byte (fill_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_full  (cmd_full),
        .init_busy (init_busy),
        .cmd_push  (cmd_push),
        .cmd_ctl   (fe_ctl),
        .cmd_row   (fe_row),
        .cmd_last  (fe_last)
    );

    vbfs_queue #(
        .DATA_W (CMD_W)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data ({fe_ctl, fe_row, fe_last}),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (q_out),
        .empty     (cmd_empty)
    );

    assign {be_ctl, be_row, be_last} = q_out;

    vbfs_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .LAYER_COUNT (LAYER_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_ctl   (be_ctl),
        .cmd_row   (be_row),
        .cmd_last  (be_last),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .init_busy (init_busy)
    );

    vbfs_queue #(
        .DATA_W (RES_W)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign in_range  = res_out.in_range;
    assign voxel_bit = res_out.voxel_bit;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vbfs_pkg::*;

    localparam int GRID_W      = 128;
    localparam int GRID_H      = 128;
    localparam int LAYERS      = 8;
    localparam int ROW_BYTES   = (GRID_W + 7) / 8;
    localparam int LAYER_BYTES = GRID_H * ROW_BYTES;
    localparam int STORE_BYTES = LAYERS * LAYER_BYTES;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam int HOT_SLOTS       = 12;
    localparam int DRAIN_SLACK     = 8;
    localparam int END_SLACK       = 40;
    localparam int WATCHDOG_CYCLES = 12000;
    localparam int PRINT_LIMIT     = 50;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [2:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               lit;
        logic [BYTE_W-1:0]  fill;
    } voxel_cmd_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [2:0]         op;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] z_layer;
    logic               lit;
    logic [BYTE_W-1:0]  fill_byte;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;
    logic               empty;
    logic               pop;
    logic               in_range;
    logic               voxel_bit;

    logic [7:0]         voxel_mirror [STORE_BYTES];
    logic               swap_mirror;
    result_t            pending_results [$];
    idle_mode_t         idle_mode;
    int                 error_count;
    int                 quiet_cycles = 0;
    logic [COORD_W-1:0] hot_x [HOT_SLOTS];
    logic [COORD_W-1:0] hot_y [HOT_SLOTS];
    logic [COORD_W-1:0] hot_z [HOT_SLOTS];

    voxel_bit_frame_store #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H),
        .LAYER_COUNT (LAYERS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .z_layer   (z_layer),
        .lit       (lit),
        .fill_byte (fill_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .in_range  (in_range),
        .voxel_bit (voxel_bit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 84;
            IDLE_BOTH:   return 24;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 84;
            IDLE_BOTH:     return 24;
            default:       return 0;
        endcase
    endfunction

    function automatic int draw_gap(input int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct)
            n++;
        return n;
    endfunction

    function automatic voxel_cmd_t voxel_cmd(input logic [2:0] c_op, input int cx,
                                             input int cy, input int cz, input logic c_lit,
                                             input int c_fill);
        voxel_cmd_t c;
        c.op   = c_op;
        c.x    = COORD_W'(cx);
        c.y    = COORD_W'(cy);
        c.z    = COORD_W'(cz);
        c.lit  = c_lit;
        c.fill = BYTE_W'(c_fill);
        return c;
    endfunction

    // Updates the shadow store and returns the result the block must give for this item.
    function automatic result_t apply_voxel_cmd(input voxel_cmd_t c);
        result_t     r;
        logic        hit;
        int unsigned col;
        int unsigned row;
        int unsigned byte_at;
        int unsigned bit_at;
        r       = '0;
        hit     = (c.x < GRID_W) && (c.y < GRID_H) && (c.z < LAYERS);
        col     = swap_mirror ? 32'(c.y) : 32'(c.x);
        row     = swap_mirror ? 32'(c.x) : 32'(c.y);
        hit     = hit && (col < GRID_W) && (row < GRID_H);
        byte_at = c.z * LAYER_BYTES + row * ROW_BYTES + (col >> 3);
        bit_at  = col & 7;
        hit     = hit && (byte_at < STORE_BYTES);
        case (c.op)
            OP_WRITE:
            begin
                if (hit)
                begin
                    voxel_mirror[byte_at][bit_at] = c.lit;
                    r.in_range = 1'b1;
                end
            end
            OP_READ:
            begin
                if (hit)
                begin
                    r.voxel_bit = voxel_mirror[byte_at][bit_at];
                    r.in_range  = 1'b1;
                end
            end
            OP_CLEAR_ALL:
            begin
                foreach (voxel_mirror[i])
                    voxel_mirror[i] = '0;
                r.in_range = 1'b1;
            end
            OP_CLEAR_LAYER, OP_FILL_LAYER:
            begin
                if (c.z < LAYERS)
                begin
                    for (int i = 0; i < LAYER_BYTES; i++)
                        voxel_mirror[c.z * LAYER_BYTES + i] = (c.op == OP_FILL_LAYER) ? c.fill : '0;
                    r.in_range = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic voxel_cmd_t random_voxel_cmd();
        voxel_cmd_t  c;
        int unsigned pick;
        int unsigned slot;
        pick = $urandom_range(99);
        slot = $urandom_range(HOT_SLOTS - 1);
        if ($urandom_range(15) == 0)
        begin
            hot_x[slot] = COORD_W'($urandom_range(GRID_W - 1));
            hot_y[slot] = COORD_W'($urandom_range(GRID_H - 1));
            hot_z[slot] = COORD_W'($urandom_range(LAYERS - 1));
        end
        c = voxel_cmd(OP_READ, hot_x[slot], hot_y[slot], hot_z[slot], 1'($urandom_range(1)),
                      $urandom_range(255));
        if (pick < 40)
            c.op = OP_WRITE;
        else if (pick < 75)
            c.op = OP_READ;
        else if (pick < 84)
        begin
            c.op = (pick < 80) ? OP_WRITE : OP_READ;
            c.x  = COORD_W'($urandom_range(255));
            c.y  = COORD_W'($urandom_range(255));
            c.z  = ($urandom_range(1) == 0) ? COORD_W'($urandom_range(255))
                                             : COORD_W'($urandom_range(LAYERS - 1));
        end
        else if (pick < 89)
        begin
            c.op = OP_FILL_LAYER;
            c.z  = (pick == 88) ? COORD_W'($urandom_range(255))
                                : COORD_W'($urandom_range(LAYERS - 1));
        end
        else if (pick < 93)
        begin
            c.op = OP_CLEAR_LAYER;
            c.z  = (pick == 92) ? COORD_W'($urandom_range(255))
                                : COORD_W'($urandom_range(LAYERS - 1));
        end
        else if (pick < 94)
            c.op = OP_CLEAR_ALL;
        else if (pick < 97)
            c.op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
        else
            c = voxel_cmd(3'($urandom_range(OP_UNUSED_LAST)), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255), 1'($urandom_range(1)),
                          $urandom_range(255));
        return c;
    endfunction

    // Push stays high on return so that back-to-back items need no gap.
    task automatic send_item(input voxel_cmd_t c);
        int gap;
        gap = draw_gap(sender_idle_pct());
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        op        <= c.op;
        x_coord   <= c.x;
        y_coord   <= c.y;
        z_layer   <= c.z;
        lit       <= c.lit;
        fill_byte <= c.fill;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(apply_voxel_cmd(c));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_swap(input logic value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        swap_mirror = value;
        @(posedge clk);
    endtask

    task automatic test_directed();
        write_swap(1'b0);
        idle_mode = IDLE_NONE;
        send_item(voxel_cmd(OP_WRITE, 0, 0, 0, 1'b1, 0));
        send_item(voxel_cmd(OP_READ, 0, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_WRITE, GRID_W - 1, GRID_H - 1, LAYERS - 1, 1'b1, 0));
        send_item(voxel_cmd(OP_READ, GRID_W - 1, GRID_H - 1, LAYERS - 1, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, GRID_W - 1, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_WRITE, 0, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, 0, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_WRITE, GRID_W, 0, 0, 1'b1, 0));
        send_item(voxel_cmd(OP_READ, GRID_W, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, 0, 255, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_WRITE, 0, GRID_H, 0, 1'b1, 0));
        send_item(voxel_cmd(OP_READ, 0, 0, LAYERS, 1'b0, 0));
        send_item(voxel_cmd(OP_WRITE, 255, 255, 255, 1'b1, 255));
        send_item(voxel_cmd(OP_FILL_LAYER, 255, 255, 0, 1'b1, 8'hA5));
        send_item(voxel_cmd(OP_READ, 0, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, 1, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, 7, GRID_H - 1, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_FILL_LAYER, 0, 0, LAYERS, 1'b0, 8'hFF));
        send_item(voxel_cmd(OP_FILL_LAYER, 0, 0, 255, 1'b0, 8'hFF));
        send_item(voxel_cmd(OP_CLEAR_LAYER, 0, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, 0, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_CLEAR_LAYER, 0, 0, 255, 1'b0, 0));
        send_item(voxel_cmd(OP_CLEAR_ALL, 0, 0, 0, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, GRID_W - 1, GRID_H - 1, LAYERS - 1, 1'b0, 0));
        for (int c_op = OP_UNUSED_FIRST; c_op <= OP_UNUSED_LAST; c_op++)
            send_item(voxel_cmd(3'(c_op), 1, 1, 1, 1'b1, 8'hFF));
    endtask

    task automatic test_swap_axes();
        wait_drained();
        write_swap(1'b1);
        send_item(voxel_cmd(OP_WRITE, 5, 90, 3, 1'b1, 0));
        send_item(voxel_cmd(OP_READ, 5, 90, 3, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, 90, 5, 3, 1'b0, 0));
        send_item(voxel_cmd(OP_WRITE, GRID_W, 5, 3, 1'b1, 0));
        wait_drained();
        write_swap(1'b0);
        send_item(voxel_cmd(OP_READ, 90, 5, 3, 1'b0, 0));
        send_item(voxel_cmd(OP_READ, 5, 90, 3, 1'b0, 0));
    endtask

    task automatic test_random(input idle_mode_t mode, input logic swap, input int count);
        int pause_at;
        wait_drained();
        write_swap(swap);
        idle_mode = mode;
        pause_at  = $urandom_range(count - 1, count / 4);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_drained();
            send_item(random_voxel_cmd());
        end
    endtask

    initial
    begin
        result_t want;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("item with nothing expected, in_range=%0b voxel_bit=%0b",
                                              in_range, voxel_bit));
                else
                begin
                    want = pending_results.pop_front();
                    if (in_range !== want.in_range)
                        report_mismatch($sformatf("in_range got %0b want %0b", in_range,
                                                  want.in_range));
                    if (voxel_bit !== want.voxel_bit)
                        report_mismatch($sformatf("voxel_bit got %0b want %0b", voxel_bit,
                                                  want.voxel_bit));
                end
            end
            pop <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        push      <= 1'b0;
        op        <= OP_WRITE;
        x_coord   <= '0;
        y_coord   <= '0;
        z_layer   <= '0;
        lit       <= 1'b0;
        fill_byte <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        error_count  = 0;
        swap_mirror  = 1'b0;
        idle_mode    = IDLE_NONE;
        foreach (voxel_mirror[i])
            voxel_mirror[i] = '0;
        for (int i = 0; i < HOT_SLOTS; i++)
        begin
            hot_x[i] = COORD_W'($urandom_range(GRID_W - 1));
            hot_y[i] = COORD_W'($urandom_range(GRID_H - 1));
            hot_z[i] = COORD_W'($urandom_range(LAYERS - 1));
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_swap_axes();
        test_random(IDLE_NONE, 1'b0, 140);
        test_random(IDLE_SENDER, 1'b1, 100);
        test_random(IDLE_RECEIVER, 1'b0, 120);
        test_random(IDLE_BOTH, 1'b1, 140);
        wait_drained();
        repeat (END_SLACK) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
